[sv/pdc_pkg.sv]
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants of the PID duty controller
// Register map, mode codes, sequencer states and multiplier control struct.
// ----------------------------------------------------------------------------
package pdc_pkg;

    // field widths
    localparam int COUNT_W = 16;
    localparam int VOLT_W  = 16;
    localparam int ERR_W   = 17;
    localparam int DERIV_W = 18;
    localparam int SUM_W   = 32;
    localparam int GAIN_W  = 16;
    localparam int DUTY_W  = 7;
    localparam int ACC_W   = 51;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // duty limits and fixed-point scale (1/4096 V)
    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd99;
    localparam logic [DUTY_W-1:0] DUTY_MIN = 7'd1;
    localparam int                VOLT_SHIFT = 12;
    localparam logic signed [ACC_W-1:0] ACC_LO = 51'sd4096;
    localparam logic signed [ACC_W-1:0] ACC_HI = 51'sd409600;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_TARGET = 3'd1;
    localparam logic [2:0] REG_SCALE  = 3'd2;
    localparam logic [2:0] REG_OFFSET = 3'd3;
    localparam logic [2:0] REG_GAIN_P = 3'd4;
    localparam logic [2:0] REG_GAIN_I = 3'd5;
    localparam logic [2:0] REG_GAIN_D = 3'd6;

    // mode codes; the unused code runs the full PID law
    localparam logic [1:0] MODE_ONOFF = 2'd0;
    localparam logic [1:0] MODE_PROP  = 2'd1;
    localparam logic [1:0] MODE_PID   = 2'd2;

    // reset values
    localparam logic [15:0] SCALE_RST = 16'd16384;

    // gain term order on the shared multiplier
    localparam logic [1:0] TERM_P = 2'd0;
    localparam logic [1:0] TERM_D = 2'd1;
    localparam logic [1:0] TERM_I = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOLT,
        ST_ERR,
        ST_UPD,
        ST_MUL,
        ST_FIN
    } pdc_state_t;

    // control of the serial multiply-accumulate unit
    typedef struct packed {
        logic clear;   // preload accumulator with the offset term
        logic load;    // load multiplicand and gain bits
        logic step;    // consume one gain bit
        logic last;    // gain sign bit: subtract instead of add
    } pdc_mac_ctrl_t;

endpackage

[sv/pdc_if.sv]
// ----------------------------------------------------------------------------
// pdc_in_if / pdc_out_if: valid-ready channels of the duty controller
// One transfer moves one measurement in, or one duty result out.
// ----------------------------------------------------------------------------
interface pdc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] measured_count;

    modport source (output valid, output measured_count, input ready);
    modport sink   (input valid, input measured_count, output ready);
endinterface

interface pdc_out_if;
    logic               valid;
    logic               ready;
    logic [6:0]         duty;
    logic signed [16:0] error_now;

    modport source (output valid, output duty, output error_now, input ready);
    modport sink   (input valid, input duty, input error_now, output ready);
endinterface

[sv/pdc_serial_mac.sv]
// ----------------------------------------------------------------------------
// pdc_serial_mac: bit-serial signed multiply-accumulate
// Consumes one gain bit per step cycle, LSB first; the multiplicand shifts left.
// ----------------------------------------------------------------------------
module pdc_serial_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pdc_pkg::pdc_mac_ctrl_t               ctrl,
    input  logic signed [pdc_pkg::ACC_W-1:0]     init_acc,
    input  logic signed [pdc_pkg::ACC_W-1:0]     mcand,
    input  logic        [pdc_pkg::GAIN_W-1:0]    gain,
    output logic signed [pdc_pkg::ACC_W-1:0]     acc
);
    import pdc_pkg::*;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  mcand_reg, mcand_next;
    logic        [GAIN_W-1:0] gbits_reg, gbits_next;
    logic signed [ACC_W-1:0]  addend;

    // partial product of the current gain bit
    assign addend = gbits_reg[0] ? mcand_reg : '0;

    always_comb
    begin
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        gbits_next = gbits_reg;
        if (ctrl.clear)
        begin
            acc_next = init_acc;
        end
        else if (ctrl.step)
        begin
            // two's complement: the sign bit of the gain weighs negative
            acc_next = ctrl.last ? (acc_reg - addend) : (acc_reg + addend);
        end
        if (ctrl.load)
        begin
            mcand_next = mcand;
            gbits_next = gain;
        end
        else if (ctrl.step)
        begin
            mcand_next = mcand_reg <<< 1;
            gbits_next = gbits_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gbits_reg <= '0;
        end
        else
        begin
            gbits_reg <= gbits_next;
        end
    end

    // data path registers
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
    end

    assign acc = acc_reg;

endmodule

[sv/pid_duty_controller_unit.sv]
// ----------------------------------------------------------------------------
// pid_duty_controller_unit: measured count to PWM duty, on-off / P / PID
// Voltage via a 16-step shift-add multiplier, gain terms via a bit-serial MAC.
// ----------------------------------------------------------------------------
// On-off mode takes the result from the error sign alone; proportional mode
// runs the P term and PID mode the P, D and I terms in turn on the MAC. The
// serial multipliers work one bit per cycle.
// One item at a time; a new item is taken while the result register waits.
// rst_n resets the control and config registers; last_error/error_sum go to 0.
// ----------------------------------------------------------------------------
module pid_duty_controller_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    pdc_in_if.sink                        meas,
    pdc_out_if.source                     result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pdc_pkg::ADDR_W-1:0]    paddr,
    input  logic [pdc_pkg::DATA_W-1:0]    pwdata,
    output logic [pdc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import pdc_pkg::*;

    // configuration registers
    logic [1:0]               mode_reg;
    logic [VOLT_W-1:0]        target_reg;
    logic [15:0]              scale_reg;
    logic [DUTY_W-1:0]        offset_reg;
    logic signed [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic                     cfg_wr;

    // sequencer
    pdc_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [1:0] term_reg, term_next;
    logic       last_bit, full_pid;

    // data path
    logic [COUNT_W-1:0]        count_reg;
    logic [31:0]               mp_reg, mp_next;
    logic [16:0]               mp_sum;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [DERIV_W-1:0] deriv_reg, deriv_next;
    logic signed [ERR_W-1:0]   last_err_reg;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [19:0]        err5;
    logic signed [SUM_W:0]     sum_wide;
    logic                      in_window;

    // result register
    logic                      out_full_reg, out_full_next;
    logic [DUTY_W-1:0]         duty_reg, duty_calc;
    logic signed [ERR_W-1:0]   out_err_reg;

    // control from the output decoder
    logic          in_ready, volt_step, err_load, upd_en, out_load;
    pdc_mac_ctrl_t mac_ctrl;
    logic [1:0]    term_sel;
    logic signed [ACC_W-1:0]  mac_init, mac_mcand, acc;
    logic        [GAIN_W-1:0] mac_gain;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PID;
            target_reg <= '0;
            scale_reg  <= SCALE_RST;
            offset_reg <= '0;
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_MODE:   mode_reg   <= pwdata[1:0];
                REG_TARGET: target_reg <= pwdata[15:0];
                REG_SCALE:  scale_reg  <= pwdata[15:0];
                REG_OFFSET: offset_reg <= pwdata[6:0];
                REG_GAIN_P: gain_p_reg <= pwdata[15:0];
                REG_GAIN_I: gain_i_reg <= pwdata[15:0];
                REG_GAIN_D: gain_d_reg <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (paddr[4:2])
            REG_MODE:   prdata = {30'd0, mode_reg};
            REG_TARGET: prdata = {16'd0, target_reg};
            REG_SCALE:  prdata = {16'd0, scale_reg};
            REG_OFFSET: prdata = {25'd0, offset_reg};
            REG_GAIN_P: prdata = {16'd0, gain_p_reg};
            REG_GAIN_I: prdata = {16'd0, gain_i_reg};
            REG_GAIN_D: prdata = {16'd0, gain_d_reg};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    assign last_bit = (cnt_reg == 4'd15);
    assign full_pid = (mode_reg != MODE_ONOFF) && (mode_reg != MODE_PROP);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (meas.valid) state_next = ST_VOLT;
            ST_VOLT: if (last_bit) state_next = ST_ERR;
            ST_ERR:  state_next = (mode_reg == MODE_ONOFF) ? ST_FIN : ST_UPD;
            ST_UPD:  state_next = ST_MUL;
            ST_MUL:
            begin
                if (last_bit && (!full_pid || term_reg == TERM_I))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:  if (!out_full_reg || result.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready  = 1'b0;
        volt_step = 1'b0;
        err_load  = 1'b0;
        upd_en    = 1'b0;
        out_load  = 1'b0;
        mac_ctrl  = '0;
        term_sel  = TERM_P;
        unique case (state_reg)
            ST_IDLE: in_ready  = 1'b1;
            ST_VOLT: volt_step = 1'b1;
            ST_ERR:  err_load  = 1'b1;
            ST_UPD:
            begin
                upd_en         = full_pid;
                mac_ctrl.clear = 1'b1;
                mac_ctrl.load  = 1'b1;
            end
            ST_MUL:
            begin
                mac_ctrl.step = 1'b1;
                mac_ctrl.last = last_bit;
                mac_ctrl.load = last_bit && full_pid && (term_reg != TERM_I);
                term_sel      = term_reg + 2'd1;
            end
            ST_FIN:  out_load = !out_full_reg || result.ready;
            default: ;
        endcase
    end

    // bit and term counters
    always_comb
    begin
        cnt_next  = cnt_reg;
        term_next = term_reg;
        if (in_ready && meas.valid)
        begin
            cnt_next = '0;
        end
        else if (volt_step || mac_ctrl.step)
        begin
            cnt_next = cnt_reg + 4'd1;
        end
        if (mac_ctrl.clear)
        begin
            term_next = TERM_P;
        end
        else if (mac_ctrl.load)
        begin
            term_next = term_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            term_reg  <= TERM_P;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            term_reg  <= term_next;
        end
    end

    // ------------------------------------------------------------------
    // Voltage: shift-add count * scale, one scale bit per cycle
    // ------------------------------------------------------------------
    assign mp_sum = {1'b0, mp_reg[31:16]} + ({17{mp_reg[0]}} & {1'b0, count_reg});

    always_comb
    begin
        mp_next = mp_reg;
        if (in_ready && meas.valid)
        begin
            mp_next = {16'd0, scale_reg};
        end
        else if (volt_step)
        begin
            mp_next = {mp_sum, mp_reg[15:1]};
        end
    end

    // ------------------------------------------------------------------
    // Error, derivative, windowed saturating integral
    // ------------------------------------------------------------------
    assign err_next   = $signed({1'b0, target_reg}) - $signed({1'b0, mp_reg[31:16]});
    assign deriv_next = DERIV_W'(err_reg) - DERIV_W'(last_err_reg);
    assign err5       = (20'(err_reg) <<< 2) + 20'(err_reg);
    assign in_window  = err5 < $signed({4'd0, target_reg});
    assign sum_wide   = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(err_reg);

    always_comb
    begin
        if (!in_window)
        begin
            sum_next = '0;
        end
        else if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            // clamp to the 32-bit signed range
            sum_next = {sum_wide[SUM_W], {(SUM_W-1){!sum_wide[SUM_W]}}};
        end
        else
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg <= '0;
            sum_reg      <= '0;
        end
        else if (upd_en)
        begin
            last_err_reg <= err_reg;
            sum_reg      <= sum_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && meas.valid)
        begin
            count_reg <= meas.measured_count;
        end
        mp_reg <= mp_next;
        if (err_load)
        begin
            err_reg <= err_next;
        end
        if (upd_en)
        begin
            deriv_reg <= deriv_next;
        end
    end

    // ------------------------------------------------------------------
    // Gain terms on the shared serial MAC
    // ------------------------------------------------------------------
    assign mac_init = ACC_W'({offset_reg, {VOLT_SHIFT{1'b0}}});

    always_comb
    begin
        case (term_sel)
            TERM_P:
            begin
                mac_mcand = ACC_W'(err_reg);
                mac_gain  = gain_p_reg;
            end
            TERM_D:
            begin
                mac_mcand = ACC_W'(deriv_reg);
                mac_gain  = gain_d_reg;
            end
            default:
            begin
                mac_mcand = ACC_W'(sum_reg);
                mac_gain  = gain_i_reg;
            end
        endcase
    end

    pdc_serial_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .init_acc (mac_init),
        .mcand    (mac_mcand),
        .gain     (mac_gain),
        .acc      (acc)
    );

    // ------------------------------------------------------------------
    // Duty: on-off by error sign, else truncate by 4096 and clamp to 1..99
    // ------------------------------------------------------------------
    always_comb
    begin
        if (mode_reg == MODE_ONOFF)
        begin
            duty_calc = (err_reg > 0) ? DUTY_MAX : DUTY_MIN;
        end
        else if (acc < ACC_LO)
        begin
            duty_calc = DUTY_MIN;
        end
        else if (acc >= ACC_HI)
        begin
            duty_calc = DUTY_MAX;
        end
        else
        begin
            duty_calc = acc[VOLT_SHIFT+DUTY_W-1:VOLT_SHIFT];
        end
    end

    // result register; frees on a transfer, reloads in the same cycle
    always_comb
    begin
        out_full_next = out_full_reg;
        if (out_load)
        begin
            out_full_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else
        begin
            out_full_reg <= out_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            duty_reg    <= duty_calc;
            out_err_reg <= err_reg;
        end
    end

    assign meas.ready       = in_ready;
    assign result.valid     = out_full_reg;
    assign result.duty      = duty_reg;
    assign result.error_now = out_err_reg;

endmodule

[sv/pdc_checker.sv]
// ----------------------------------------------------------------------------
// pdc_checker: port-level checks of the PID duty controller
// Watches both channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [6:0]  duty,
    input logic [16:0] error_now
);
    import pdc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(duty) && $stable(error_now)))
        else $error("result changed while stalled");

    // duty always lands in the clamp window
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty >= DUTY_MIN && duty <= DUTY_MAX))
        else $error("duty outside 1..99");

    // error magnitude never reaches 2^16
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (error_now != 17'h10000))
        else $error("error_now out of range");

    // an input transfer starts a multi-cycle computation
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while busy");

endmodule

bind pid_duty_controller_unit pdc_checker u_pdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (meas.valid),
    .in_ready  (meas.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .duty      (result.duty),
    .error_now (result.error_now)
);

[sim/pid_duty_controller_unit_test.sv]
// ----------------------------------------------------------------------------
// pid_duty_controller_unit_test: self-checking bench of the PID duty controller
// Drives measured counts over the input channel and register writes over the
// APB port, predicts each duty and error result in the bench, and checks every
// output transfer in order against the prediction. Directed checks cover the
// three control laws, the integral window, register masking, back-pressure and
// integral accumulation; random rounds sweep configurations and idle patterns.
// ----------------------------------------------------------------------------
module pid_duty_controller_unit_test;

    import pdc_pkg::*;

    localparam int         STALL_LIMIT = 5000;    // cycles with no transfer
    localparam int         ROUND_ITEMS = 170;
    localparam int         RAMP_ITEMS  = 200;
    localparam logic [2:0] REG_UNUSED  = 3'd7;    // unmapped register slot
    localparam logic [1:0] MODE_SPARE  = 2'd3;    // unused mode code

    typedef struct packed {
        logic [DUTY_W-1:0]       duty;
        logic signed [ERR_W-1:0] error_now;
    } duty_result_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    pdc_in_if  meas_if ();
    pdc_out_if result_if ();

    // register mirror
    logic [1:0]               cfg_mode;
    logic [15:0]              cfg_target;
    logic [15:0]              cfg_scale;
    logic [DUTY_W-1:0]        cfg_offset;
    logic signed [GAIN_W-1:0] cfg_kp;
    logic signed [GAIN_W-1:0] cfg_ki;
    logic signed [GAIN_W-1:0] cfg_kd;

    // loop state mirror
    logic signed [ERR_W-1:0]  model_last_err;
    logic signed [SUM_W-1:0]  error_integral;

    duty_result_t duty_results_q[$];

    int mismatches;
    int src_idle_pct;
    int sink_stall_pct;
    bit sink_hold;
    int quiet_cycles;

    pid_duty_controller_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .meas    (meas_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result ready, random stalls or a long hold
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_if.ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [DUTY_W-1:0] clamp_duty(input longint acc);
        longint pct;
        pct = acc / 4096;    // truncates toward zero
        if (pct > 99)
            pct = 99;
        if (pct < 1)
            pct = 1;
        return pct[DUTY_W-1:0];
    endfunction

    function automatic void predict_duty(input logic [15:0] cnt);
        longint       volt;
        longint       err;
        longint       deriv;
        longint       sum;
        longint       acc;
        duty_result_t exp_res;
        volt = (longint'(cnt) * longint'(cfg_scale)) >>> 16;
        err  = longint'(cfg_target) - volt;
        case (cfg_mode)
            MODE_ONOFF:
                exp_res.duty = (volt < longint'(cfg_target)) ? DUTY_MAX : DUTY_MIN;
            MODE_PROP:
            begin
                acc = longint'(cfg_offset) * 4096 + err * longint'(cfg_kp);
                exp_res.duty = clamp_duty(acc);
            end
            default:
            begin
                deriv          = err - longint'(model_last_err);
                model_last_err = err[ERR_W-1:0];
                // integral window with saturation, else cleared
                if (err * 5 < longint'(cfg_target))
                begin
                    sum = longint'(error_integral) + err;
                    if (sum > 64'sd2147483647)
                        sum = 64'sd2147483647;
                    if (sum < -64'sd2147483648)
                        sum = -64'sd2147483648;
                end
                else
                    sum = 0;
                error_integral = sum[SUM_W-1:0];
                acc = longint'(cfg_offset) * 4096 + err * longint'(cfg_kp)
                    + deriv * longint'(cfg_kd) + longint'(error_integral) * longint'(cfg_ki);
                exp_res.duty = clamp_duty(acc);
            end
        endcase
        exp_res.error_now = err[ERR_W-1:0];
        duty_results_q.push_back(exp_res);
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        duty_result_t exp_res;
        if (result_if.valid && result_if.ready)
        begin
            if (duty_results_q.size() == 0)
            begin
                $error("result with no expectation: duty=%0d error_now=%0d",
                       result_if.duty, result_if.error_now);
                mismatches++;
            end
            else
            begin
                exp_res = duty_results_q.pop_front();
                if (result_if.duty !== exp_res.duty)
                begin
                    $error("duty: expected %0d, actual %0d", exp_res.duty, result_if.duty);
                    mismatches++;
                end
                if (result_if.error_now !== exp_res.error_now)
                begin
                    $error("error_now: expected %0d, actual %0d",
                           exp_res.error_now, result_if.error_now);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((meas_if.valid && meas_if.ready) || (result_if.valid && result_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        case (idx)
            REG_MODE:   cfg_mode   = data[1:0];
            REG_TARGET: cfg_target = data[15:0];
            REG_SCALE:  cfg_scale  = data[15:0];
            REG_OFFSET: cfg_offset = data[DUTY_W-1:0];
            REG_GAIN_P: cfg_kp     = data[15:0];
            REG_GAIN_I: cfg_ki     = data[15:0];
            REG_GAIN_D: cfg_kd     = data[15:0];
            default:    ;    // unmapped slot is ignored
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_all(input logic [1:0] mode, input logic [15:0] target,
                             input logic [15:0] scale, input logic [31:0] offset,
                             input logic [31:0] kp, input logic [31:0] ki,
                             input logic [31:0] kd);
        write_reg(REG_MODE, {30'd0, mode});
        write_reg(REG_TARGET, {16'd0, target});
        write_reg(REG_SCALE, {16'd0, scale});
        write_reg(REG_OFFSET, offset);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
    endtask

    // one measurement transfer, with random idle cycles ahead of it
    task automatic send_count(input logic [15:0] cnt);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            meas_if.valid <= 1'b0;
            @(negedge clk);
        end
        meas_if.valid          <= 1'b1;
        meas_if.measured_count <= cnt;
        do
        begin
            @(posedge clk);
        end
        while (!meas_if.ready);
        predict_duty(cnt);
    endtask

    // stop sending and wait for every predicted result
    task automatic drain_results(input int settle);
        @(negedge clk);
        meas_if.valid <= 1'b0;
        while (duty_results_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            1:       begin src_idle_pct = 77; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 77; end
            3:       begin src_idle_pct = 24; sink_stall_pct = 24; end
            default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        endcase
    endtask

    task automatic hold_sink(input int cycles);
        sink_hold = 1'b1;
        repeat (cycles) @(posedge clk);
        sink_hold = 1'b0;
    endtask

    // half the counts land near the set point, half anywhere
    function automatic logic [15:0] pick_count();
        longint center;
        if ($urandom_range(1) == 0 || cfg_scale == 16'd0)
            return 16'($urandom_range(65535));
        center = (longint'(cfg_target) << 16) / longint'(cfg_scale);
        center = center + longint'($urandom_range(64)) - 32;
        if (center > 65535)
            center = 65535;
        if (center < 0)
            center = 0;
        return center[15:0];
    endfunction

    // mostly small gains so the duty stays off the clamp; upper bits random
    function automatic logic [31:0] pick_gain();
        int g;
        if ($urandom_range(3) == 0)
            return $urandom();
        g = int'($urandom_range(400)) - 200;
        return {16'($urandom_range(65535)), g[15:0]};
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        set_idling(0);
        send_count(16'd0);
        send_count(16'd65535);
        send_count(16'd40000);
        drain_results(8);
    endtask

    task automatic test_on_off();
        write_all(MODE_ONOFF, 16'd1000, 16'd65535, 32'd0, 32'd0, 32'd0, 32'd0);
        send_count(16'd1000);     // just below the set point
        send_count(16'd1001);     // equal to the set point
        send_count(16'd0);
        send_count(16'd65535);
        drain_results(8);
    endtask

    task automatic test_proportional();
        write_all(MODE_PROP, 16'd1000, 16'd65535, 32'd50, 32'd1, 32'd0, 32'd0);
        send_count(16'd4001);
        send_count(16'd0);
        drain_results(8);
        // largest positive error
        write_reg(REG_TARGET, 32'd65535);
        send_count(16'd0);
        drain_results(8);
        // offset above 100, then largest negative error with the most negative gain
        write_reg(REG_OFFSET, 32'd127);
        write_reg(REG_GAIN_P, 32'd0);
        send_count(16'd500);
        drain_results(8);
        write_reg(REG_TARGET, 32'd0);
        write_reg(REG_OFFSET, 32'd0);
        write_reg(REG_GAIN_P, 32'hFFFF_8000);
        send_count(16'd65535);
        drain_results(8);
    endtask

    // integral window edges: error just inside, on the edge, negative, zero; then the unused mode code
    task automatic test_pid_window();
        write_all(MODE_PID, 16'd5000, 16'd65535, 32'd40, 32'd2, 32'd1, 32'd3);
        send_count(16'd4002);
        send_count(16'd4003);
        send_count(16'd4001);
        send_count(16'd6001);
        send_count(16'd5001);
        drain_results(8);
        write_reg(REG_MODE, {30'd0, MODE_SPARE});
        send_count(16'd3000);
        send_count(16'd7000);
        drain_results(8);
    endtask

    // wide writes are cut to the register width; the unmapped slot does nothing
    task automatic test_register_masking();
        write_reg(REG_MODE, 32'hFFFF_FFFD);
        write_reg(REG_TARGET, 32'hABCD_1234);
        write_reg(REG_OFFSET, 32'hFFFF_FFE5);
        write_reg(REG_GAIN_P, 32'h1234_FFFF);
        write_reg(REG_UNUSED, 32'd0);
        send_count(16'd2000);
        send_count(16'd9000);
        drain_results(8);
    endtask

    // receiver held off while the sender keeps offering
    task automatic test_backpressure();
        write_all(MODE_PID, 16'd3000, 16'd40000, 32'd50, 32'd3, 32'd1, 32'hFFFF_FFFE);
        set_idling(0);
        fork
            hold_sink(300);
            begin
                repeat (16) send_count(pick_count());
            end
        join
        drain_results(8);
    endtask

    task automatic test_random();
        for (int r = 0; r < 8; r++)
        begin
            if (r == 0)
                write_all(MODE_ONOFF, 16'd0, 16'd65535, 32'd0, 32'hFFFF_8000,
                          32'hFFFF_8000, 32'hFFFF_8000);
            else if (r == 7)
                write_all(MODE_ONOFF, 16'd65535, 16'd65535, 32'd127, 32'h7FFF,
                          32'h7FFF, 32'h7FFF);
            else
                write_all(2'((r + r / 4) % 4), 16'($urandom_range(65535)),
                          (r == 3) ? 16'd0 : 16'($urandom_range(65535)),
                          $urandom_range(127), pick_gain(), pick_gain(), pick_gain());
            set_idling(r % 4);
            repeat (ROUND_ITEMS) send_count(pick_count());
            drain_results(8);
        end
        set_idling(0);
    endtask

    // long run at the largest negative error; the integral grows by -65534 per item
    // and catches up with the proportional term over the last few items
    task automatic test_integral_ramp();
        write_all(MODE_PID, 16'd0, 16'd65535, 32'd0, 32'd195, 32'hFFFF, 32'd0);
        set_idling(0);
        send_count(16'd1);    // zero error clears the integral
        repeat (RAMP_ITEMS) send_count(16'd65535);
        drain_results(8);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        meas_if.valid          = 1'b0;
        meas_if.measured_count = '0;
        sink_hold              = 1'b0;
        mismatches             = 0;
        quiet_cycles           = 0;
        src_idle_pct           = 0;
        sink_stall_pct         = 0;
        cfg_mode               = MODE_PID;
        cfg_target             = '0;
        cfg_scale              = SCALE_RST;
        cfg_offset             = '0;
        cfg_kp                 = '0;
        cfg_ki                 = '0;
        cfg_kd                 = '0;
        model_last_err         = '0;
        error_integral         = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_on_off();
        test_proportional();
        test_pid_window();
        test_register_masking();
        test_backpressure();
        test_random();
        test_integral_ramp();

        drain_results(80);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
